[src/ipt_pkg.sv]
// ----------------------------------------------------------------------------
// ipt_pkg
// shared types and constants for the ipv4 address and port text parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] MAX_COMPONENTS = 3'd4;
    localparam int         QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_DOT,
        CLS_COLON,
        CLS_TERM,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       first;
    } t_token;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_PORT,
        PH_DONE
    } t_phase;

endpackage

`default_nettype wire

[src/ipt_front.sv]
// ----------------------------------------------------------------------------
// ipt_front
// accepts characters and classifies them into tokens for the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipt_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [7:0]      i_char_in,
    input  wire logic            i_first,
    output logic                 o_tok_valid,
    output ipt_pkg::t_token      o_tok,
    input  wire logic            i_tok_full
);

    logic [3:0] w_digit_off;

    assign w_digit_off = 4'(i_char_in - ipt_pkg::CHAR_ZERO);

    always_comb begin
        o_tok.first = i_first;
        o_tok.digit = w_digit_off;
        if (i_char_in >= ipt_pkg::CHAR_ZERO && i_char_in <= ipt_pkg::CHAR_NINE) begin
            o_tok.cls = ipt_pkg::CLS_DIGIT;
        end else if (i_char_in == ipt_pkg::CHAR_DOT) begin
            o_tok.cls = ipt_pkg::CLS_DOT;
        end else if (i_char_in == ipt_pkg::CHAR_COLON) begin
            o_tok.cls = ipt_pkg::CLS_COLON;
        end else if (i_char_in == ipt_pkg::CHAR_NUL || i_char_in == ipt_pkg::CHAR_LF ||
                     i_char_in == ipt_pkg::CHAR_CR) begin
            o_tok.cls = ipt_pkg::CLS_TERM;
        end else begin
            o_tok.cls = ipt_pkg::CLS_OTHER;
        end
    end

    assign o_in_stall  = i_tok_full;
    assign o_tok_valid = i_in_valid && !i_tok_full;

endmodule

`default_nettype wire

[src/ipt_queue.sv]
// ----------------------------------------------------------------------------
// ipt_queue
// short token queue between the classifier and the parse engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipt_queue #(
    parameter int DEPTH = ipt_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire ipt_pkg::t_token i_wr_tok,
    output logic                 o_full,
    input  wire logic            i_rd,
    output logic                 o_rd_valid,
    output ipt_pkg::t_token      o_rd_tok
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ipt_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            w_do_rd;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_tok   = r_mem[r_rd_ptr];
    assign w_do_rd    = i_rd && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !w_do_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && w_do_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_tok;
        end
    end

endmodule

`default_nettype wire

[src/ipt_back.sv]
// ----------------------------------------------------------------------------
// ipt_back
// parse engine: runs the address and port state machine on queued tokens
// and holds the result in an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tok_valid,
    input  wire ipt_pkg::t_token i_tok,
    output logic                 o_tok_rd,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic                 o_ok,
    output logic [31:0]          o_address,
    output logic [2:0]           o_components,
    output logic                 o_port_present,
    output logic [15:0]          o_port
);

    ipt_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_acc,   n_acc;
    logic [2:0]      r_cnt,   n_cnt;
    logic [31:0]     r_addr,  n_addr;
    logic            r_seen,  n_seen;

    logic            r_out_valid;
    logic            r_ok;
    logic [31:0]     r_address;
    logic [2:0]      r_components;
    logic            r_port_present;
    logic [15:0]     r_port;

    ipt_pkg::t_phase w_phase;
    logic [15:0]     w_acc;
    logic [2:0]      w_cnt;
    logic [31:0]     w_addr;
    logic            w_seen;
    logic [15:0]     w_acc_mul;
    logic [31:0]     w_addr_store;
    logic            w_full;
    logic            w_emit;
    logic            w_emit_ok;
    logic            w_emit_pp;

    assign o_tok_rd = i_tok_valid && (!r_out_valid || !i_out_stall);

    // state as seen by this token, after a restart
    assign w_phase = i_tok.first ? ipt_pkg::PH_ADDR : r_phase;
    assign w_acc   = i_tok.first ? 16'd0 : r_acc;
    assign w_cnt   = i_tok.first ? 3'd0  : r_cnt;
    assign w_addr  = i_tok.first ? 32'd0 : r_addr;
    assign w_seen  = i_tok.first ? 1'b0  : r_seen;

    assign w_acc_mul = {w_acc[12:0], 3'b000} + {w_acc[14:0], 1'b0} + {12'd0, i_tok.digit};
    assign w_full    = (w_cnt >= ipt_pkg::MAX_COMPONENTS);

    always_comb begin
        w_addr_store = w_addr;
        unique case (w_cnt[1:0])
            2'd0: w_addr_store[31:24] = w_addr[31:24] | w_acc[7:0];
            2'd1: w_addr_store[23:16] = w_addr[23:16] | w_acc[7:0];
            2'd2: w_addr_store[15:8]  = w_addr[15:8]  | w_acc[7:0];
            2'd3: w_addr_store[7:0]   = w_addr[7:0]   | w_acc[7:0];
        endcase
    end

    always_comb begin
        n_phase   = w_phase;
        n_acc     = w_acc;
        n_cnt     = w_cnt;
        n_addr    = w_addr;
        n_seen    = w_seen;
        w_emit    = 1'b0;
        w_emit_ok = 1'b0;
        w_emit_pp = 1'b0;
        unique case (w_phase)
            ipt_pkg::PH_ADDR: begin
                n_seen = 1'b1;
                unique case (i_tok.cls)
                    ipt_pkg::CLS_DOT, ipt_pkg::CLS_COLON: begin
                        if (w_full) begin
                            w_emit = 1'b1;
                        end else begin
                            n_addr = w_addr_store;
                            n_cnt  = w_cnt + 1'b1;
                            n_acc  = 16'd0;
                            if (i_tok.cls == ipt_pkg::CLS_COLON) begin
                                n_phase = ipt_pkg::PH_PORT;
                            end
                        end
                    end
                    ipt_pkg::CLS_TERM: begin
                        w_emit = 1'b1;
                        if (!w_full) begin
                            n_addr    = w_addr_store;
                            n_cnt     = w_cnt + 1'b1;
                            n_acc     = 16'd0;
                            w_emit_ok = w_seen;
                        end
                    end
                    ipt_pkg::CLS_DIGIT: begin
                        n_acc = w_acc_mul;
                    end
                    default: begin
                        w_emit = 1'b1;
                    end
                endcase
            end
            ipt_pkg::PH_PORT: begin
                if (i_tok.cls == ipt_pkg::CLS_DIGIT) begin
                    n_acc = w_acc_mul;
                end else begin
                    w_emit    = 1'b1;
                    w_emit_ok = 1'b1;
                    w_emit_pp = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            n_phase = ipt_pkg::PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ipt_pkg::PH_ADDR;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_addr      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_tok_rd) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_addr  <= n_addr;
                r_seen  <= n_seen;
            end
            if (o_tok_rd && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_rd && w_emit) begin
            r_ok           <= w_emit_ok;
            r_address      <= n_addr;
            r_components   <= n_cnt;
            r_port_present <= w_emit_pp;
            r_port         <= w_emit_pp ? w_acc : 16'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_ok;
    assign o_address      = r_address;
    assign o_components   = r_components;
    assign o_port_present = r_port_present;
    assign o_port         = r_port;

endmodule

`default_nettype wire

[src/ipv4_port_text_parser.sv]
// ----------------------------------------------------------------------------
// ipv4_port_text_parser
// parses "a.b.c.d[:port]" text, one character per item, into one result
// ----------------------------------------------------------------------------
// Takes one character per cycle unless stalled, gives one result per string;
// the result is registered once the string's last token has left the queue,
// or later while a result is held. A set first flag starts a new string. The
// classifier and the parse engine are parted by a token queue of QUEUE_DEPTH
// entries and the engine by its output register, so input flows at one item
// per cycle while results are taken at once; a held result stops the engine,
// the queue fills and then the input stalls until the result is taken. The
// engine does one multiply-by-ten and one byte insert per token, which sets
// the cycle.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_port_text_parser #(
    parameter int QUEUE_DEPTH = ipt_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_first,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_ok,
    output logic [31:0]      o_address,
    output logic [2:0]       o_components,
    output logic             o_port_present,
    output logic [15:0]      o_port
);

    logic            w_wr;
    ipt_pkg::t_token w_wr_tok;
    logic            w_full;
    logic            w_rd;
    logic            w_rd_valid;
    ipt_pkg::t_token w_rd_tok;

    ipt_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_in   (i_char_in),
        .i_first     (i_first),
        .o_tok_valid (w_wr),
        .o_tok       (w_wr_tok),
        .i_tok_full  (w_full)
    );

    ipt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_wr_tok   (w_wr_tok),
        .o_full     (w_full),
        .i_rd       (w_rd),
        .o_rd_valid (w_rd_valid),
        .o_rd_tok   (w_rd_tok)
    );

    ipt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (w_rd_valid),
        .i_tok          (w_rd_tok),
        .o_tok_rd       (w_rd),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ok           (o_ok),
        .o_address      (o_address),
        .o_components   (o_components),
        .o_port_present (o_port_present),
        .o_port         (o_port)
    );

endmodule

`default_nettype wire

[src/ipt_checker.sv]
// ----------------------------------------------------------------------------
// ipt_checker
// port-level checks for the ipv4 address and port text parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_char_in,
    input wire logic        i_first,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_ok,
    input wire logic [31:0] o_address,
    input wire logic [2:0]  o_components,
    input wire logic        o_port_present,
    input wire logic [15:0] o_port
);

    // stalled input keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_char_in) && $stable(i_first))
        else $error("input changed while stalled");

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_address) &&
        $stable(o_port) && $stable(o_ok) && $stable(o_components))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a good parse stored at least one component, never more than four
    a_ok_components: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ok |-> o_components != 3'd0 && o_components <= 3'd4)
        else $error("bad component count on good parse");

    // port only with success, and zero when absent
    a_port_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_port_present ? o_ok : (o_port == 16'd0)))
        else $error("port fields inconsistent");

endmodule

bind ipv4_port_text_parser ipt_checker u_ipt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_char_in      (i_char_in),
    .i_first        (i_first),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_ok           (o_ok),
    .o_address      (o_address),
    .o_components   (o_components),
    .o_port_present (o_port_present),
    .o_port         (o_port)
);

`default_nettype wire
